// File: hdl/ppc_pkg.sv
package ppc_pkg;

   localparam int POS_W      = 24;
   localparam int ANG_W      = 16;
   localparam int DIFF_W     = 25;
   localparam int ANGX_W     = 18;
   localparam int CW         = 28;
   localparam int MAGP_W     = 46;
   localparam int RHO_W      = 27;
   localparam int PL_W       = 43;
   localparam int PA_W       = 34;
   localparam int LW         = 36;
   localparam int LIM_W      = 15;
   localparam int NW         = 51;
   localparam int DW         = 36;
   localparam int DIV_CW     = $clog2(NW);
   localparam int IN_W       = 64;
   localparam int OUT_W      = 40;

   localparam int POS_TOL      = 1966;
   localparam int HEAD_TOL     = 410;
   localparam int CORDIC_ITERS = 16;
   localparam int CORD_CW      = $clog2(CORDIC_ITERS);

   localparam logic signed [ANGX_W-1:0] ANG_PI      = 18'sd25736;
   localparam logic signed [ANGX_W-1:0] ANG_HALF_PI = 18'sd12868;
   localparam logic signed [ANGX_W-1:0] ANG_TWO_PI  = 18'sd51472;
   localparam logic signed [CW-1:0]     Z_HALF_PI   = 28'sd26353589;
   localparam logic signed [17:0]       INV_GAIN    = 18'sd39797;

   localparam logic [2:0] REG_GOAL_X     = 3'd0;
   localparam logic [2:0] REG_GOAL_Y     = 3'd1;
   localparam logic [2:0] REG_GOAL_HEAD  = 3'd2;
   localparam logic [2:0] REG_GAIN_DIST  = 3'd3;
   localparam logic [2:0] REG_GAIN_BEAR  = 3'd4;
   localparam logic [2:0] REG_GAIN_FINAL = 3'd5;
   localparam logic [2:0] REG_MAX_LIN    = 3'd6;
   localparam logic [2:0] REG_MAX_ANG    = 3'd7;

   localparam logic [1:0] PH_POLAR    = 2'd0;
   localparam logic [1:0] PH_TURN     = 2'd1;
   localparam logic [1:0] PH_STRAIGHT = 2'd2;
   localparam logic [1:0] PH_DONE     = 2'd3;

   typedef struct packed {
      logic load;
      logic cord;
      logic mag;
      logic mul;
      logic sum;
      logic scl1;
      logic div1;
      logic scl2;
      logic div2;
      logic fin;
      logic first;
      logic simp;
      logic out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic started;
      logic polar;
      logic cord_last;
      logic need1;
      logic need2;
      logic div_done;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [CW-1:0] atan_val(input logic [4:0] i);
      logic signed [CW-1:0] r;
      unique case (i)
         5'd0:  r = 28'sd13176795;
         5'd1:  r = 28'sd7778716;
         5'd2:  r = 28'sd4110061;
         5'd3:  r = 28'sd2086331;
         5'd4:  r = 28'sd1047215;
         5'd5:  r = 28'sd524117;
         5'd6:  r = 28'sd262123;
         5'd7:  r = 28'sd131070;
         5'd8:  r = 28'sd65536;
         5'd9:  r = 28'sd32768;
         5'd10: r = 28'sd16384;
         5'd11: r = 28'sd8192;
         5'd12: r = 28'sd4096;
         5'd13: r = 28'sd2048;
         5'd14: r = 28'sd1024;
         5'd15: r = 28'sd512;
         5'd16: r = 28'sd256;
         5'd17: r = 28'sd128;
         5'd18: r = 28'sd64;
         5'd19: r = 28'sd32;
         5'd20: r = 28'sd16;
         5'd21: r = 28'sd8;
         5'd22: r = 28'sd4;
         5'd23: r = 28'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [ANGX_W-1:0] wrap_ang(input logic signed [ANGX_W-1:0] a);
      logic signed [ANGX_W-1:0] r;
      if (a > ANG_PI) begin
         r = a - ANG_TWO_PI;
      end else if (a < -ANG_PI) begin
         r = a + ANG_TWO_PI;
      end else begin
         r = a;
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] neg_sat(input logic signed [POS_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v == {1'b1, {(POS_W-1){1'b0}}}) begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

// File: hdl/polar_pose_controller_unit.sv
// Unicycle pose controller: one velocity command beat for every pose beat.
// The req_ channel carries measured poses, the rsp_ channel carries the
// commanded linear and angular speed with the phase and a done flag.
// Goal, gains and speed limits go on the csr_ port, written by the user only
// while idle; the block does not enforce it. A write acts on the next pose.
// A pose in the polar approach phase, and the very first pose, runs
// through a 16-step vectoring CORDIC; a polar pose then passes a gain
// multiply stage, and its speed limiting uses a shared 51-step bit-serial
// divider once or twice, once for each limit that applies. A turn,
// straight or done pose skips the CORDIC and the divider.
// One pose is processed at a time; the next pose is taken as soon as the
// result sits in the output register, even if it is not yet taken.
// When the receiver stalls, the result holds on rsp_tdata and a finished
// second result waits until the first is taken.
// Synchronous reset restores the default configuration, clears the
// started and reverse flags and returns to the polar approach phase.
module polar_pose_controller_unit import ppc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // pose_x[23:0], pose_y[47:24], pose_heading[63:48]
   input  logic [IN_W-1:0]   req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // linear_speed[15:0], angular_speed[31:16], phase[33:32], done_res[34]
   output logic [OUT_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [POS_W-1:0]  csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quo;
   logic [DW-1:0] div_den;

   ppc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .div_start  (div_start),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_quo    (div_quo),
      .div_done   (div_done)
   );

   ppc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

endmodule

// File: hdl/ppc_div.sv
module ppc_div import ppc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo,
   output logic          done
);

   logic [NW-1:0]     q_ff;
   logic [DW:0]       r_ff;
   logic [DW-1:0]     den_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DW:0]       shifted;
   logic [DW+1:0]     trial;

   assign shifted = {r_ff[DW-1:0], q_ff[NW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign quo     = q_ff;
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(NW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         r_ff   <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         if (!trial[DW+1]) begin
            r_ff <= trial[DW:0];
            q_ff <= {q_ff[NW-2:0], 1'b1};
         end else begin
            r_ff <= shifted;
            q_ff <= {q_ff[NW-2:0], 1'b0};
         end
      end
   end

endmodule

// File: hdl/ppc_dpath.sv
module ppc_dpath import ppc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic [IN_W-1:0]   req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [POS_W-1:0]  csr_wdata,
   output logic              div_start,
   output logic [NW-1:0]     div_num,
   output logic [DW-1:0]     div_den,
   input  logic [NW-1:0]     div_quo,
   input  logic              div_done
);

   logic signed [POS_W-1:0]  gx_ff, gy_ff;
   logic signed [ANG_W-1:0]  gh_cfg_ff, kp_ff, ka_ff, kb_ff;
   logic [LIM_W-1:0]         vmax_ff, wmax_ff;

   logic                     started_ff, reverse_ff, rsp_valid_ff;
   logic [1:0]               phase_ff;
   logic signed [POS_W-1:0]  held_x_ff, held_y_ff, px_ff, py_ff;
   logic signed [ANG_W-1:0]  held_h_ff, ph_ff;

   logic signed [CW-1:0]     cx_ff, cy_ff, cz_ff;
   logic [CORD_CW-1:0]       it_ff;
   logic                     zero_ff;
   logic signed [MAGP_W-1:0] magp_ff;
   logic signed [ANGX_W-1:0] theta_ff;
   logic signed [PL_W-1:0]   plin_ff;
   logic signed [PA_W-1:0]   pa_ff, pb_ff;
   logic signed [LW-1:0]     lin_ff, rot_ff;
   logic [1:0]               pout_ff;
   logic                     done_ff;
   logic [OUT_W-1:0]         rsp_data_ff;

   logic signed [POS_W-1:0]  in_x, in_y, src_x, src_y;
   logic signed [ANG_W-1:0]  in_h;
   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [CW-1:0]     lx, ly, lz, xs, ys, zr;
   logic signed [RHO_W-1:0]  rho;
   logic signed [ANGX_W-1:0] gh, alpha, beta, a_first, e1;
   logic signed [DIFF_W-1:0] e2, ex, ey;
   logic signed [LW-1:0]     linr, wmax_s, vmax_s, q_s;
   logic [LW-1:0]            lin_mag, rot_mag;
   logic signed [POS_W-1:0]  hx_new, hy_new;
   logic                     rev_first;

   assign in_x  = req_tdata[23:0];
   assign in_y  = req_tdata[47:24];
   assign in_h  = req_tdata[63:48];
   assign src_x = started_ff ? held_x_ff : in_x;
   assign src_y = started_ff ? held_y_ff : in_y;
   assign dx    = DIFF_W'(gx_ff) - DIFF_W'(src_x);
   assign dy    = DIFF_W'(gy_ff) - DIFF_W'(src_y);

   always_comb begin
      if (dx < 0) begin
         if (dy >= 0) begin
            lx = CW'(dy);
            ly = -CW'(dx);
            lz = Z_HALF_PI;
         end else begin
            lx = -CW'(dy);
            ly = CW'(dx);
            lz = -Z_HALF_PI;
         end
      end else begin
         lx = CW'(dx);
         ly = CW'(dy);
         lz = '0;
      end
   end

   assign xs = cx_ff >>> it_ff;
   assign ys = cy_ff >>> it_ff;
   assign zr = (cz_ff + 28'sd1024) >>> 11;

   assign rho     = zero_ff ? '0 : RHO_W'((magp_ff + 46'sd32768) >>> 16);
   assign gh      = wrap_ang(ANGX_W'(gh_cfg_ff));
   assign alpha   = wrap_ang(theta_ff - ANGX_W'(held_h_ff));
   assign beta    = wrap_ang(gh - theta_ff);
   assign a_first = wrap_ang(theta_ff - ANGX_W'(ph_ff));
   assign rev_first = ((a_first < 0) ? -a_first : a_first) > ANG_HALF_PI;
   assign linr    = LW'((plin_ff + 43'sd128) >>> 8);

   assign lin_mag = lin_ff[LW-1] ? LW'(-lin_ff) : LW'(lin_ff);
   assign rot_mag = rot_ff[LW-1] ? LW'(-rot_ff) : LW'(rot_ff);
   assign wmax_s  = LW'(wmax_ff);
   assign vmax_s  = LW'(vmax_ff);
   assign q_s     = LW'(div_quo);

   assign div_start = (cmd.scl1 && status.need1) || (cmd.scl2 && status.need2);
   assign div_num   = cmd.scl1 ? NW'(lin_mag) * NW'(wmax_ff) : NW'(rot_mag) * NW'(vmax_ff);
   assign div_den   = cmd.scl1 ? rot_mag : lin_mag;

   assign hx_new = reverse_ff ? neg_sat(px_ff) : px_ff;
   assign hy_new = reverse_ff ? neg_sat(py_ff) : py_ff;
   assign ex     = DIFF_W'(hx_new) - DIFF_W'(gx_ff);
   assign ey     = DIFF_W'(hy_new) - DIFF_W'(gy_ff);
   assign e1     = ANGX_W'(ph_ff) - gh;
   assign e2     = DIFF_W'(py_ff) - DIFF_W'(gy_ff);

   assign status.started   = started_ff;
   assign status.polar     = (phase_ff == PH_POLAR);
   assign status.cord_last = (it_ff == CORD_CW'(CORDIC_ITERS - 1));
   assign status.need1     = rot_mag > wmax_s;
   assign status.need2     = lin_mag > vmax_s;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff        <= '0;
         gy_ff        <= '0;
         gh_cfg_ff    <= 16'sd12868;
         kp_ff        <= 16'sd768;
         ka_ff        <= 16'sd2048;
         kb_ff        <= -16'sd384;
         vmax_ff      <= 15'd5243;
         wmax_ff      <= 15'd1638;
         started_ff   <= 1'b0;
         reverse_ff   <= 1'b0;
         phase_ff     <= PH_POLAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_GOAL_X:     gx_ff     <= csr_wdata;
               REG_GOAL_Y:     gy_ff     <= csr_wdata;
               REG_GOAL_HEAD:  gh_cfg_ff <= csr_wdata[15:0];
               REG_GAIN_DIST:  kp_ff     <= csr_wdata[15:0];
               REG_GAIN_BEAR:  ka_ff     <= csr_wdata[15:0];
               REG_GAIN_FINAL: kb_ff     <= csr_wdata[15:0];
               REG_MAX_LIN:    vmax_ff   <= csr_wdata[14:0];
               REG_MAX_ANG:    wmax_ff   <= csr_wdata[14:0];
            endcase
         end
         if (cmd.first) begin
            started_ff <= 1'b1;
            reverse_ff <= rev_first;
         end
         if (cmd.fin) begin
            if (((ex < 0) ? -ex : ex) < DIFF_W'(POS_TOL)
                && ((ey < 0) ? -ey : ey) < DIFF_W'(POS_TOL)) begin
               phase_ff <= PH_TURN;
            end
         end
         if (cmd.simp) begin
            priority if (phase_ff == PH_TURN
                         && ((e1 < 0) ? -e1 : e1) > ANGX_W'(HEAD_TOL)) begin
               phase_ff <= PH_TURN;
            end else if ((phase_ff == PH_TURN || phase_ff == PH_STRAIGHT)
                         && ((e2 < 0) ? -e2 : e2) > DIFF_W'(POS_TOL)) begin
               phase_ff <= PH_STRAIGHT;
            end else begin
               phase_ff <= PH_DONE;
            end
         end
         if (cmd.out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff   <= in_x;
         py_ff   <= in_y;
         ph_ff   <= in_h;
         cx_ff   <= lx;
         cy_ff   <= ly;
         cz_ff   <= lz;
         it_ff   <= '0;
         zero_ff <= (dx == 0) && (dy == 0);
      end
      if (cmd.cord) begin
         it_ff <= it_ff + 1'b1;
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + atan_val(5'(it_ff));
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - atan_val(5'(it_ff));
         end
      end
      if (cmd.mag) begin
         magp_ff  <= cx_ff * INV_GAIN;
         theta_ff <= zero_ff ? '0 : ANGX_W'(zr);
      end
      if (cmd.mul) begin
         plin_ff <= kp_ff * rho;
         pa_ff   <= ka_ff * alpha;
         pb_ff   <= kb_ff * beta;
      end
      if (cmd.sum) begin
         lin_ff <= reverse_ff ? -linr : linr;
         rot_ff <= LW'((35'(pa_ff) + 35'(pb_ff) + 35'sd128) >>> 8);
      end
      if (cmd.div1) begin
         lin_ff <= lin_ff[LW-1] ? -q_s : q_s;
         rot_ff <= rot_ff[LW-1] ? -wmax_s : wmax_s;
      end
      if (cmd.div2) begin
         rot_ff <= rot_ff[LW-1] ? -q_s : q_s;
         lin_ff <= lin_ff[LW-1] ? -vmax_s : vmax_s;
      end
      if (cmd.fin) begin
         held_x_ff <= hx_new;
         held_y_ff <= hy_new;
         held_h_ff <= ph_ff;
         pout_ff   <= PH_POLAR;
         done_ff   <= 1'b0;
      end
      if (cmd.first) begin
         held_x_ff <= rev_first ? neg_sat(px_ff) : px_ff;
         held_y_ff <= rev_first ? neg_sat(py_ff) : py_ff;
         held_h_ff <= ANG_W'(wrap_ang(ANGX_W'(ph_ff)));
         lin_ff    <= '0;
         rot_ff    <= '0;
         pout_ff   <= PH_POLAR;
         done_ff   <= 1'b0;
      end
      if (cmd.simp) begin
         priority if (phase_ff == PH_TURN
                      && ((e1 < 0) ? -e1 : e1) > ANGX_W'(HEAD_TOL)) begin
            rot_ff  <= (e1 > 0) ? -wmax_s : wmax_s;
            lin_ff  <= '0;
            pout_ff <= PH_TURN;
            done_ff <= 1'b0;
         end else if ((phase_ff == PH_TURN || phase_ff == PH_STRAIGHT)
                      && ((e2 < 0) ? -e2 : e2) > DIFF_W'(POS_TOL)) begin
            lin_ff  <= (e2 > 0) ? -vmax_s : vmax_s;
            rot_ff  <= '0;
            pout_ff <= PH_STRAIGHT;
            done_ff <= 1'b0;
         end else begin
            lin_ff  <= '0;
            rot_ff  <= '0;
            pout_ff <= PH_DONE;
            done_ff <= 1'b1;
         end
      end
      if (cmd.out) begin
         rsp_data_ff <= {5'b0, done_ff, pout_ff, rot_ff[15:0], lin_ff[15:0]};
      end
   end

endmodule

// File: hdl/ppc_ctrl.sv
module ppc_ctrl import ppc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CORD  = 4'd1;
   localparam logic [3:0] S_MAG   = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_SCL1  = 4'd5;
   localparam logic [3:0] S_DIV1  = 4'd6;
   localparam logic [3:0] S_SCL2  = 4'd7;
   localparam logic [3:0] S_DIV2  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_FIRST = 4'd10;
   localparam logic [3:0] S_SIMP  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (!status.started || status.polar) ? S_CORD : S_SIMP;
            end
         end
         S_CORD: begin
            cmd.cord = 1'b1;
            if (status.cord_last) begin
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.mag  = 1'b1;
            state_in = status.started ? S_MUL : S_FIRST;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_SCL1;
         end
         S_SCL1: begin
            cmd.scl1 = 1'b1;
            state_in = status.need1 ? S_DIV1 : S_SCL2;
         end
         S_DIV1: begin
            if (status.div_done) begin
               cmd.div1 = 1'b1;
               state_in = S_SCL2;
            end
         end
         S_SCL2: begin
            cmd.scl2 = 1'b1;
            state_in = status.need2 ? S_DIV2 : S_FIN;
         end
         S_DIV2: begin
            if (status.div_done) begin
               cmd.div2 = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_FIRST: begin
            cmd.first = 1'b1;
            state_in  = S_OUT;
         end
         S_SIMP: begin
            cmd.simp = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: tb/polar_pose_controller_unit_checker.sv
module polar_pose_controller_unit_checker import ppc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [IN_W-1:0]   req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [OUT_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [POS_W-1:0]  csr_wdata,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] linear_speed;
      logic [15:0] angular_speed;
      logic [1:0]  phase;
      logic        done_res;
   } velocity_cmd_type;

   velocity_cmd_type commands_due[$];

   logic signed [23:0] goal_x, goal_y;
   logic signed [15:0] goal_heading, kp_q, ka_q, kb_q;
   logic [14:0]        lin_limit, ang_limit;

   logic        started, backward;
   logic [1:0]  ctl_phase;
   longint      held_x, held_y, held_heading;

   longint arctan_steps [16] = '{13176795, 7778716, 4110061, 2086331, 1047215, 524117,
                                 262123, 131070, 65536, 32768, 16384, 8192, 4096, 2048,
                                 1024, 512};

   assign pending = commands_due.size();

   function automatic longint absval(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint wrap_pi(input longint a);
      if (a > 25736) return a - 51472;
      if (a < -25736) return a + 51472;
      return a;
   endfunction

   function automatic longint negate_pos(input longint v);
      return (-v > 8388607) ? 8388607 : -v;
   endfunction

   task automatic bearing_range(input longint dx, input longint dy,
                                output longint ang, output longint range_mag);
      longint x, y, z, t, nx, ny;
      x = dx;
      y = dy;
      z = 0;
      if (dx == 0 && dy == 0) begin
         ang = 0;
         range_mag = 0;
         return;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 26353589;
         end else begin
            x = -y; y = t; z = -26353589;
         end
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_steps[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_steps[i];
         end
         x = nx;
         y = ny;
      end
      ang = (z + 1024) >>> 11;
      range_mag = (x * 39797 + 32768) >>> 16;
   endtask

   task automatic predict_command(input logic [IN_W-1:0] pose);
      longint px, py, ph, gx, gy, gh, vmax, wmax, lin, rot, theta, rho, e;
      velocity_cmd_type c;
      px = longint'($signed(pose[23:0]));
      py = longint'($signed(pose[47:24]));
      ph = longint'($signed(pose[63:48]));
      gx = goal_x;
      gy = goal_y;
      gh = wrap_pi(goal_heading);
      vmax = lin_limit;
      wmax = ang_limit;
      lin = 0;
      rot = 0;
      c.phase = ctl_phase;
      c.done_res = 1'b0;
      if (!started) begin
         bearing_range(gx - px, gy - py, theta, rho);
         started = 1'b1;
         backward = absval(wrap_pi(theta - ph)) > 12868;
         held_x = backward ? negate_pos(px) : px;
         held_y = backward ? negate_pos(py) : py;
         held_heading = wrap_pi(ph);
         c.phase = PH_POLAR;
      end else if (ctl_phase == PH_POLAR) begin
         bearing_range(gx - held_x, gy - held_y, theta, rho);
         lin = (kp_q * rho + 128) >>> 8;
         rot = (ka_q * wrap_pi(theta - held_heading) + kb_q * wrap_pi(gh - theta) + 128) >>> 8;
         held_x = backward ? negate_pos(px) : px;
         held_y = backward ? negate_pos(py) : py;
         held_heading = ph;
         if (backward) lin = -lin;
         if (absval(rot) > wmax) begin
            lin = (lin * wmax) / absval(rot);
            rot = rot > 0 ? wmax : -wmax;
         end
         if (absval(lin) > vmax) begin
            rot = (rot * vmax) / absval(lin);
            lin = lin > 0 ? vmax : -vmax;
         end
         if (absval(held_x - gx) < POS_TOL && absval(held_y - gy) < POS_TOL) begin
            ctl_phase = PH_TURN;
         end
         c.phase = PH_POLAR;
      end else begin
         if (ctl_phase == PH_TURN) begin
            e = ph - gh;
            if (absval(e) > HEAD_TOL) begin
               rot = e > 0 ? -wmax : wmax;
               c.phase = PH_TURN;
            end else begin
               ctl_phase = PH_STRAIGHT;
            end
         end
         if (ctl_phase == PH_STRAIGHT) begin
            e = py - gy;
            if (absval(e) > POS_TOL) begin
               lin = e > 0 ? -vmax : vmax;
               c.phase = PH_STRAIGHT;
            end else begin
               ctl_phase = PH_DONE;
            end
         end
         if (ctl_phase == PH_DONE) begin
            lin = 0;
            rot = 0;
            c.phase = PH_DONE;
            c.done_res = 1'b1;
         end
      end
      c.linear_speed = lin[15:0];
      c.angular_speed = rot[15:0];
      commands_due.push_back(c);
   endtask

   always @(posedge clock) begin
      velocity_cmd_type want;
      if (reset) begin
         goal_x <= '0;
         goal_y <= '0;
         goal_heading <= 16'sd12868;
         kp_q <= 16'sd768;
         ka_q <= 16'sd2048;
         kb_q <= -16'sd384;
         lin_limit <= 15'd5243;
         ang_limit <= 15'd1638;
         started <= 1'b0;
         backward <= 1'b0;
         ctl_phase <= PH_POLAR;
         held_x <= 0;
         held_y <= 0;
         held_heading <= 0;
         commands_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GOAL_X:     goal_x <= csr_wdata;
               REG_GOAL_Y:     goal_y <= csr_wdata;
               REG_GOAL_HEAD:  goal_heading <= csr_wdata[15:0];
               REG_GAIN_DIST:  kp_q <= csr_wdata[15:0];
               REG_GAIN_BEAR:  ka_q <= csr_wdata[15:0];
               REG_GAIN_FINAL: kb_q <= csr_wdata[15:0];
               REG_MAX_LIN:    lin_limit <= csr_wdata[14:0];
               REG_MAX_ANG:    ang_limit <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_command(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (commands_due.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = commands_due.pop_front();
               if (rsp_tdata[15:0] !== want.linear_speed) begin
                  $display("%0t: linear_speed expected %h actual %h", $time,
                           want.linear_speed, rsp_tdata[15:0]);
                  fail_count++;
               end
               if (rsp_tdata[31:16] !== want.angular_speed) begin
                  $display("%0t: angular_speed expected %h actual %h", $time,
                           want.angular_speed, rsp_tdata[31:16]);
                  fail_count++;
               end
               if (rsp_tdata[33:32] !== want.phase) begin
                  $display("%0t: phase expected %h actual %h", $time,
                           want.phase, rsp_tdata[33:32]);
                  fail_count++;
               end
               if (rsp_tdata[34] !== want.done_res) begin
                  $display("%0t: done_res expected %h actual %h", $time,
                           want.done_res, rsp_tdata[34]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// File: tb/polar_pose_controller_unit_test.sv
module polar_pose_controller_unit_test import ppc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [OUT_W-1:0]  rsp_tdata;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = REG_GOAL_X;
   logic [POS_W-1:0]  csr_wdata = '0;
   int                fail_count, pending;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int goal_x_now = 0, goal_y_now = 0;

   always #5 clock = ~clock;

   polar_pose_controller_unit uut (.*);
   polar_pose_controller_unit_checker check (.*);

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_pose(input logic [23:0] x, input logic [23:0] y, input logic [15:0] h);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {h, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[23:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_GOAL_X) goal_x_now = $signed(val[23:0]);
      if (idx == REG_GOAL_Y) goal_y_now = $signed(val[23:0]);
   endtask

   task automatic load_setup(input int gx, input int gy, input int gh, input int kp,
                             input int ka, input int kb, input int vmax, input int wmax);
      write_reg(REG_GOAL_X, gx);
      write_reg(REG_GOAL_Y, gy);
      write_reg(REG_GOAL_HEAD, gh);
      write_reg(REG_GAIN_DIST, kp);
      write_reg(REG_GAIN_BEAR, ka);
      write_reg(REG_GAIN_FINAL, kb);
      write_reg(REG_MAX_LIN, vmax);
      write_reg(REG_MAX_ANG, wmax);
   endtask

   function automatic int pick16(input bit edges);
      if (edges) return $urandom_range(1) ? 32767 : -32768;
      return $signed(16'($urandom));
   endfunction

   // The block runs in reverse, so a pose ends the approach when its negation nears the goal.
   task automatic send_far_pose(input logic [23:0] x, input logic [23:0] y, input logic [15:0] h);
      int nx, ny;
      nx = ($signed(x) == -8388608) ? 8388607 : -$signed(x);
      ny = ($signed(y) == -8388608) ? 8388607 : -$signed(y);
      if ((nx - goal_x_now < 2500) && (goal_x_now - nx < 2500) &&
          (ny - goal_y_now < 2500) && (goal_y_now - ny < 2500)) begin
         x[22] = ~x[22];
      end
      send_pose(x, y, h);
   endtask

   function automatic logic [15:0] any_heading();
      return 16'($urandom_range(51472) - 25736);
   endfunction

   task automatic random_approach(input int count);
      logic [23:0] x, y;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(2) == 0) begin
            x = 24'($urandom);
            y = 24'($urandom);
         end else begin
            x = 24'(-goal_x_now + int'($urandom_range(60000)) - 30000);
            y = 24'(-goal_y_now + int'($urandom_range(60000)) - 30000);
         end
         send_far_pose(x, y, any_heading());
      end
   endtask

   task automatic random_setup(input bit edges);
      int lim;
      lim = edges ? 32767 : 8000;
      load_setup($signed(24'($urandom)), $signed(24'($urandom)),
                 edges ? ($urandom_range(1) ? 25736 : -25736) : int'($urandom_range(51472)) - 25736,
                 pick16(edges), pick16(edges), pick16(edges),
                 $urandom_range(lim), $urandom_range(lim));
   endtask

   initial begin
      int gh;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);

      load_setup(300000, -200000, 12868, 768, 2048, -384, 5243, 1638);
      // The first pose sits on the goal, facing away from it.
      send_pose(24'd300000, -24'sd200000, 16'sd25736);
      send_far_pose(24'h7FFFFF, 24'h7FFFFF, 16'sd25736);
      send_far_pose(24'h800000, 24'h800000, -16'sd25736);
      send_far_pose(24'h000000, 24'h000000, 16'sd0);
      send_far_pose(24'h800000, 24'd5, 16'sd100);
      send_far_pose(-24'sd300000, 24'd150000, 16'sd0);
      send_far_pose(-24'sd290000, 24'd210000, -16'sd12868);
      wait_idle();
      load_setup(-8388608, 8388607, -25736, 32767, -32768, 32767, 0, 32767);
      send_far_pose(24'h7FFFFF, 24'h800000, 16'sd25736);
      send_far_pose(24'h123456, 24'h654321, -16'sd9000);
      send_far_pose(24'h800000, 24'h7FFFFF, 16'sd0);
      wait_idle();
      load_setup(8388607, -8388608, 25736, -32768, 32767, -32768, 32767, 0);
      send_far_pose(24'h7FFFFF, 24'h800000, -16'sd25736);
      send_far_pose(24'h000001, 24'hFFFFFF, 16'sd3000);
      send_far_pose(24'h800000, 24'h7FFFFF, 16'sd25736);

      for (int p = 0; p < 5; p++) begin
         wait_idle();
         random_setup(p == 2);
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            3: begin send_idle_pct = 30; stall_pct = 30; end
            default: begin
               send_idle_pct = 0;
               stall_pct = 10;
               hold_left = 2000;
            end
         endcase
         random_approach(120);
      end

      wait_idle();
      send_idle_pct = 20;
      stall_pct = 20;
      load_setup(4096, -8192, 12868, 768, 2048, -384, 5243, 1638);
      random_approach(5);
      // This pose closes the approach and starts the turn in place.
      send_pose(-24'sd4096, 24'd8192, 16'sd0);
      send_pose(24'($urandom), 24'($urandom), 16'sd25736);
      send_pose(24'($urandom), 24'($urandom), -16'sd25736);
      send_pose(24'($urandom), 24'($urandom), 16'sd13279);
      wait_idle();
      write_reg(REG_MAX_ANG, 32767);
      for (int n = 0; n < 6; n++) begin
         gh = ($urandom_range(1) ? 12868 + 411 : 12868 - 411) + int'($urandom_range(10000));
         if (gh > 25736) gh = 25736;
         send_pose(24'($urandom), 24'($urandom), 16'(gh));
      end
      // A heading just inside tolerance with y far away moves straight on.
      send_pose(24'd0, 24'd100000, 16'sd13278);
      wait_idle();
      write_reg(REG_MAX_LIN, 32767);
      for (int n = 0; n < 8; n++) begin
         send_pose(24'($urandom), $urandom_range(1) ? 24'(-8192 + 1967 + int'($urandom_range(900000)))
                   : 24'(-8192 - 1967 - int'($urandom_range(900000))), any_heading());
      end
      send_pose(24'd0, 24'(-8192 + 1967), 16'sd0);
      send_pose(24'd0, 24'(-8192 - 1966), 16'sd0);
      for (int n = 0; n < 8; n++) send_pose(24'($urandom), 24'($urandom), any_heading());

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/ppc_pkg.sv
hdl/ppc_div.sv
hdl/ppc_dpath.sv
hdl/ppc_ctrl.sv
hdl/polar_pose_controller_unit.sv
tb/polar_pose_controller_unit_checker.sv
tb/polar_pose_controller_unit_test.sv
